FILE: rtl/tpr_pkg.sv
`default_nettype none

package tpr_pkg;

    localparam int unsigned KWidth      = 24;
    localparam int unsigned LevelWidth  = 16;
    localparam int unsigned PeriodWidth = 16;
    localparam int unsigned SpeedWidth  = 8;
    localparam int unsigned RunWidth    = 8;
    localparam int unsigned CfgIdxWidth = 2;
    localparam int unsigned CountWidth  = $clog2(KWidth);

    localparam logic [KWidth-1:0]     KReset       = KWidth'(1500000);
    localparam logic [LevelWidth-1:0] CutOnReset   = LevelWidth'(260);
    localparam logic [LevelWidth-1:0] CutOffReset  = LevelWidth'(250);
    localparam logic [RunWidth-1:0]   RunReset     = RunWidth'(16);
    localparam logic [PeriodWidth-1:0] SpeedClamp  = PeriodWidth'(255);

    localparam logic [CfgIdxWidth-1:0] CfgSpeedConst = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CfgCutOn      = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CfgCutOff     = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CfgRunLevel   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/tach_period_to_rpm_with_cutoff.sv
`default_nettype none

// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  period_ticks
// result    out        out_valid/out_stall speed_code, engine_running, cutoff_active,
//                                          afterstart_arm, sequential_clear
// config    in         cfg_we             cfg_index, cfg_data
//
// Each beat is accepted in the idle state, passes through the restoring divider that
// retires one quotient bit per cycle, and has its limits evaluated in the done state.
// A new beat is accepted once the divider is idle, even while a result waits.
// Reset clears the cutoff flag and the control state and sets the configuration registers to their defaults.
// A stalled result holds the finished item in the final state until taken.

module tach_period_to_rpm_with_cutoff (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [tpr_pkg::PeriodWidth-1:0]   period_ticks,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [tpr_pkg::SpeedWidth-1:0]         speed_code,
    output logic                                   engine_running,
    output logic                                   cutoff_active,
    output logic                                   afterstart_arm,
    output logic                                   sequential_clear,
    input  wire logic                              cfg_we,
    input  wire logic [tpr_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  wire logic [tpr_pkg::KWidth-1:0]        cfg_data
);

    localparam int unsigned KW = tpr_pkg::KWidth;
    localparam int unsigned PW = tpr_pkg::PeriodWidth;
    localparam int unsigned LW = tpr_pkg::LevelWidth;
    localparam int unsigned CW = tpr_pkg::CountWidth;
    localparam logic [CW-1:0] LastCount = CW'(KW - 1);

    logic [KW-1:0]               k_reg;
    logic [LW-1:0]               cut_on_reg;
    logic [LW-1:0]               cut_off_reg;
    logic [tpr_pkg::RunWidth-1:0] run_reg;
    logic                        cutoff_reg;
    logic                        cutoff_next;

    tpr_pkg::state_t state_reg;
    tpr_pkg::state_t state_next;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [KW-1:0] dividend_reg;
    logic [KW-1:0] dividend_next;
    logic [PW-1:0] period_reg;
    logic [PW-1:0] period_next;
    logic [PW-1:0] rem_reg;
    logic [PW-1:0] rem_next;
    logic [PW-1:0] quot_reg;
    logic [PW-1:0] quot_next;
    logic          ovf_reg;
    logic          ovf_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [tpr_pkg::SpeedWidth-1:0] speed_reg;
    logic                        running_reg;
    logic                        cutoff_out_reg;
    logic                        arm_reg;
    logic                        seqclr_reg;

    logic accept;
    logic div_step;
    logic finish;

    logic [PW:0]   trial;
    logic [PW:0]   trial_diff;
    logic          qbit;

    logic          stall_det;
    logic [PW-1:0] raw;
    logic [tpr_pkg::SpeedWidth-1:0] speed_val;
    logic          stopped;
    logic          flag_val;

    assign accept = in_valid && !in_stall;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg       <= tpr_pkg::KReset;
            cut_on_reg  <= tpr_pkg::CutOnReset;
            cut_off_reg <= tpr_pkg::CutOffReset;
            run_reg     <= tpr_pkg::RunReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tpr_pkg::CfgSpeedConst: k_reg       <= cfg_data;
                tpr_pkg::CfgCutOn:      cut_on_reg  <= cfg_data[LW-1:0];
                tpr_pkg::CfgCutOff:     cut_off_reg <= cfg_data[LW-1:0];
                tpr_pkg::CfgRunLevel:   run_reg     <= cfg_data[tpr_pkg::RunWidth-1:0];
                default:                ;
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tpr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tpr_pkg::ST_DIV;
                end
            end
            tpr_pkg::ST_DIV:
            begin
                if (count_reg == LastCount)
                begin
                    state_next = tpr_pkg::ST_DONE;
                end
            end
            tpr_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = tpr_pkg::ST_IDLE;
                end
            end
            default: state_next = tpr_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        in_stall = 1'b1;
        div_step = 1'b0;
        finish   = 1'b0;
        case (state_reg)
            tpr_pkg::ST_IDLE: in_stall = 1'b0;
            tpr_pkg::ST_DIV:  div_step = 1'b1;
            tpr_pkg::ST_DONE: finish   = !out_valid_reg || !out_stall;
            default:          ;
        endcase
    end

    // One restoring division step per cycle.
    assign trial      = {rem_reg, dividend_reg[KW-1]};
    assign trial_diff = trial - {1'b0, period_reg};
    assign qbit       = !trial_diff[PW];

    always_comb
    begin
        count_next    = count_reg;
        dividend_next = dividend_reg;
        period_next   = period_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        ovf_next      = ovf_reg;
        if (accept)
        begin
            count_next    = '0;
            dividend_next = k_reg;
            period_next   = period_ticks;
            rem_next      = '0;
            quot_next     = '0;
            ovf_next      = 1'b0;
        end
        else if (div_step)
        begin
            count_next    = count_reg + CW'(1);
            dividend_next = {dividend_reg[KW-2:0], 1'b0};
            rem_next      = qbit ? trial_diff[PW-1:0] : trial[PW-1:0];
            quot_next     = {quot_reg[PW-2:0], qbit};
            ovf_next      = ovf_reg || quot_reg[PW-1];
        end
    end

    // Speed, limits and cutoff hysteresis.
    always_comb
    begin
        stall_det = (period_reg == '0) || (k_reg < {{(KW-PW){1'b0}}, period_reg});
        raw       = ovf_reg ? '1 : quot_reg;
        if (stall_det)
        begin
            speed_val = '0;
        end
        else if (raw > tpr_pkg::SpeedClamp)
        begin
            speed_val = tpr_pkg::SpeedClamp[tpr_pkg::SpeedWidth-1:0];
        end
        else
        begin
            speed_val = raw[tpr_pkg::SpeedWidth-1:0];
        end
        stopped  = speed_val < run_reg;
        flag_val = cutoff_reg;
        if (stall_det)
        begin
            flag_val = 1'b0;
        end
        else
        begin
            if (raw > cut_on_reg)
            begin
                flag_val = 1'b1;
            end
            if (raw < cut_off_reg)
            begin
                flag_val = 1'b0;
            end
        end
        if (stopped)
        begin
            flag_val = 1'b0;
        end
        cutoff_next    = finish ? flag_val : cutoff_reg;
        out_valid_next = finish || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tpr_pkg::ST_IDLE;
            count_reg     <= '0;
            cutoff_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cutoff_reg    <= cutoff_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        period_reg   <= period_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        ovf_reg      <= ovf_next;
        if (finish)
        begin
            speed_reg      <= speed_val;
            running_reg    <= !stopped;
            cutoff_out_reg <= flag_val;
            arm_reg        <= stopped;
            seqclr_reg     <= stall_det;
        end
    end

    assign out_valid        = out_valid_reg;
    assign speed_code       = speed_reg;
    assign engine_running   = running_reg;
    assign cutoff_active    = cutoff_out_reg;
    assign afterstart_arm   = arm_reg;
    assign sequential_clear = seqclr_reg;

    a_stall_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sequential_clear |-> speed_code == '0)
        else $error("stalled beat carries a nonzero speed");

    a_cutoff_running: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cutoff_active |-> engine_running)
        else $error("cutoff set while engine is stopped");

    a_run_arm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> engine_running != afterstart_arm)
        else $error("running and after-start arm disagree");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tpr_pkg::ST_DIV |-> in_stall && count_reg <= LastCount)
        else $error("divider accepts input or overruns its count");

    a_flag_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> cutoff_reg == cutoff_out_reg)
        else $error("cutoff state and delivered flag differ");

endmodule

`default_nettype wire

FILE: test/tach_period_to_rpm_with_cutoff_tb.sv
`default_nettype none

module tach_period_to_rpm_with_cutoff_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandPhases    = 14;
    localparam int PeriodsPerSet = 125;
    localparam int HoldCycles    = 300;
    localparam int QuietLimit    = 4000;
    localparam int DirN          = 33;

    typedef struct packed {
        logic [tpr_pkg::SpeedWidth-1:0] speed;
        logic                           running;
        logic                           cutoff;
        logic                           arm;
        logic                           seq_clr;
    } tach_result_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_ITEM,
        ROW_KNOWN
    } row_kind_t;

    typedef struct packed {
        row_kind_t                         kind;
        logic [tpr_pkg::CfgIdxWidth-1:0]   idx;
        logic [tpr_pkg::KWidth-1:0]        data;
        logic [tpr_pkg::PeriodWidth-1:0]   period;
        tach_result_t                      want;
    } dir_row_t;

    localparam tach_result_t NoResult = '0;
    localparam tach_result_t StallStopped = '{8'd0, 1'b0, 1'b0, 1'b1, 1'b1};
    localparam tach_result_t FullCutoff = '{8'd255, 1'b1, 1'b1, 1'b0, 1'b0};

    localparam dir_row_t DirRows [DirN] = '{
        '{ROW_KNOWN, 2'd0, 24'd0, 16'd0, StallStopped},
        '{ROW_KNOWN, 2'd0, 24'd0, 16'd1, FullCutoff},
        '{ROW_ITEM, 2'd0, 24'd0, 16'd65535, NoResult},
        '{ROW_ITEM, 2'd0, 24'd0, 16'd5769, NoResult},
        '{ROW_ITEM, 2'd0, 24'd0, 16'd5000, NoResult},
        '{ROW_ITEM, 2'd0, 24'd0, 16'd5900, NoResult},
        '{ROW_ITEM, 2'd0, 24'd0, 16'd6000, NoResult},
        '{ROW_ITEM, 2'd0, 24'd0, 16'd6025, NoResult},
        '{ROW_ITEM, 2'd0, 24'd0, 16'h5555, NoResult},
        '{ROW_ITEM, 2'd0, 24'd0, 16'hAAAA, NoResult},
        '{ROW_ITEM, 2'd0, 24'd0, 16'h8000, NoResult},
        '{ROW_CFG, tpr_pkg::CfgSpeedConst, 24'd1000, 16'd0, NoResult},
        '{ROW_KNOWN, 2'd0, 24'd0, 16'd1001, StallStopped},
        '{ROW_KNOWN, 2'd0, 24'd0, 16'd1000, '{8'd1, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{ROW_CFG, tpr_pkg::CfgRunLevel, 24'd0, 16'd0, NoResult},
        '{ROW_KNOWN, 2'd0, 24'd0, 16'd0, '{8'd0, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{ROW_CFG, tpr_pkg::CfgRunLevel, 24'd255, 16'd0, NoResult},
        '{ROW_KNOWN, 2'd0, 24'd0, 16'd3, FullCutoff},
        '{ROW_CFG, tpr_pkg::CfgCutOn, 24'd0, 16'd0, NoResult},
        '{ROW_CFG, tpr_pkg::CfgCutOff, 24'd65535, 16'd0, NoResult},
        '{ROW_ITEM, 2'd0, 24'd0, 16'd4, NoResult},
        '{ROW_CFG, tpr_pkg::CfgRunLevel, 24'd1, 16'd0, NoResult},
        '{ROW_ITEM, 2'd0, 24'd0, 16'd4, NoResult},
        '{ROW_CFG, tpr_pkg::CfgSpeedConst, 24'd0, 16'd0, NoResult},
        '{ROW_KNOWN, 2'd0, 24'd0, 16'd1, StallStopped},
        '{ROW_KNOWN, 2'd0, 24'd0, 16'd65535, StallStopped},
        '{ROW_CFG, tpr_pkg::CfgSpeedConst, 24'hFFFFFF, 16'd0, NoResult},
        '{ROW_CFG, tpr_pkg::CfgCutOn, 24'd65535, 16'd0, NoResult},
        '{ROW_CFG, tpr_pkg::CfgCutOff, 24'd0, 16'd0, NoResult},
        '{ROW_ITEM, 2'd0, 24'd0, 16'd1, NoResult},
        '{ROW_CFG, tpr_pkg::CfgCutOn, 24'd65534, 16'd0, NoResult},
        '{ROW_ITEM, 2'd0, 24'd0, 16'd1, NoResult},
        '{ROW_ITEM, 2'd0, 24'd0, 16'd65535, NoResult}
    };

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic [tpr_pkg::PeriodWidth-1:0]   period_ticks;
    logic                              out_valid;
    logic                              out_stall;
    logic [tpr_pkg::SpeedWidth-1:0]    speed_code;
    logic                              engine_running;
    logic                              cutoff_active;
    logic                              afterstart_arm;
    logic                              sequential_clear;
    logic                              cfg_we;
    logic [tpr_pkg::CfgIdxWidth-1:0]   cfg_index;
    logic [tpr_pkg::KWidth-1:0]        cfg_data;

    logic [tpr_pkg::KWidth-1:0]        mdl_k;
    logic [tpr_pkg::LevelWidth-1:0]    mdl_on;
    logic [tpr_pkg::LevelWidth-1:0]    mdl_off;
    logic [tpr_pkg::RunWidth-1:0]      mdl_run;
    logic                              mdl_cutoff;

    tach_result_t pending_speeds [$];
    int errors;
    int periods_sent;
    int results_checked;
    int reg_writes;
    int quiet_cycles;
    bit no_idle;
    bit hold_req;

    tach_period_to_rpm_with_cutoff dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .period_ticks     (period_ticks),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .speed_code       (speed_code),
        .engine_running   (engine_running),
        .cutoff_active    (cutoff_active),
        .afterstart_arm   (afterstart_arm),
        .sequential_clear (sequential_clear),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic tach_result_t predict_tach(input logic [tpr_pkg::PeriodWidth-1:0] p);
        logic [tpr_pkg::KWidth-1:0]     quot;
        logic [tpr_pkg::LevelWidth-1:0] raw;
        logic [tpr_pkg::SpeedWidth-1:0] speed;
        logic                           stall;
        logic                           stopped;
        tach_result_t                   r;
        stall = (p == '0) || (mdl_k < {8'd0, p});
        speed = '0;
        if (stall)
        begin
            mdl_cutoff = 1'b0;
        end
        else
        begin
            quot = mdl_k / {8'd0, p};
            raw = (quot > 24'd65535) ? 16'hFFFF : quot[15:0];
            speed = (raw > 16'd255) ? 8'd255 : raw[7:0];
            if (raw > mdl_on && !mdl_cutoff)
            begin
                mdl_cutoff = 1'b1;
            end
            if (raw < mdl_off && mdl_cutoff)
            begin
                mdl_cutoff = 1'b0;
            end
        end
        stopped = speed < mdl_run;
        if (stopped)
        begin
            mdl_cutoff = 1'b0;
        end
        r.speed = speed;
        r.running = !stopped;
        r.cutoff = mdl_cutoff;
        r.arm = stopped;
        r.seq_clr = stall;
        return r;
    endfunction

    function automatic logic [tpr_pkg::PeriodWidth-1:0] pick_period();
        int target;
        int p;
        case ($urandom_range(0, 9))
            0: p = 0;
            1, 2: p = int'($urandom_range(0, 65535));
            3: p = int'(mdl_k) + int'($urandom_range(0, 4)) - 2;
            default:
            begin
                case ($urandom_range(0, 4))
                    0: target = int'(mdl_on);
                    1: target = int'(mdl_off);
                    2: target = int'(mdl_run);
                    3: target = 255;
                    default: target = 256;
                endcase
                target = target + int'($urandom_range(0, 4)) - 2;
                if (target < 1)
                begin
                    target = 1;
                end
                p = int'(mdl_k) / target + int'($urandom_range(0, 2)) - 1;
                if (p < 1)
                begin
                    p = 1;
                end
            end
        endcase
        if (p < 0)
        begin
            p = 0;
        end
        if (p > 65535)
        begin
            p = 65535;
        end
        return p[15:0];
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    task automatic send_period(input logic [tpr_pkg::PeriodWidth-1:0] p, input bit known,
                               input tach_result_t want);
        tach_result_t predicted;
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 11)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        period_ticks = p;
        do
        begin
            @(posedge clk);
        end
        while (in_stall !== 1'b0);
        predicted = predict_tach(p);
        pending_speeds.push_back(known ? want : predicted);
        periods_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_speeds.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_register(input logic [tpr_pkg::CfgIdxWidth-1:0] idx,
                                  input logic [tpr_pkg::KWidth-1:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        case (idx)
            tpr_pkg::CfgSpeedConst: mdl_k = data;
            tpr_pkg::CfgCutOn: mdl_on = data[15:0];
            tpr_pkg::CfgCutOff: mdl_off = data[15:0];
            default: mdl_run = data[7:0];
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Receiver side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                repeat (HoldCycles) @(negedge clk);
                hold_req = 1'b0;
            end
            out_stall = !no_idle && ($urandom_range(0, 99) < 11);
        end
    end

    always @(posedge clk)
    begin : result_check
        tach_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_speeds.size() == 0)
            begin
                $error("result beat with nothing expected: speed_code %0d", speed_code);
                errors++;
            end
            else
            begin
                want = pending_speeds.pop_front();
                check_field("speed_code", want.speed, speed_code);
                check_field("engine_running", 8'(want.running), 8'(engine_running));
                check_field("cutoff_active", 8'(want.cutoff), 8'(cutoff_active));
                check_field("afterstart_arm", 8'(want.arm), 8'(afterstart_arm));
                check_field("sequential_clear", 8'(want.seq_clr), 8'(sequential_clear));
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QuietLimit)
        begin
            $display("tach_period_to_rpm_with_cutoff_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic [tpr_pkg::KWidth-1:0]     k;
        logic [tpr_pkg::LevelWidth-1:0] on_lvl;
        logic [tpr_pkg::LevelWidth-1:0] off_lvl;
        logic [tpr_pkg::RunWidth-1:0]   run_lvl;
        int phase;
        rst_n = 1'b0;
        in_valid = 1'b0;
        period_ticks = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        periods_sent = 0;
        results_checked = 0;
        reg_writes = 0;
        quiet_cycles = 0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        mdl_k = tpr_pkg::KReset;
        mdl_on = tpr_pkg::CutOnReset;
        mdl_off = tpr_pkg::CutOffReset;
        mdl_run = tpr_pkg::RunReset;
        mdl_cutoff = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DirN; i++)
        begin
            if (DirRows[i].kind == ROW_CFG)
            begin
                wait_drained();
                write_register(DirRows[i].idx, DirRows[i].data);
            end
            else
            begin
                send_period(DirRows[i].period, DirRows[i].kind == ROW_KNOWN, DirRows[i].want);
            end
        end

        for (phase = 0; phase < RandPhases; phase++)
        begin
            wait_drained();
            case (phase)
                0:
                begin
                    k = 24'd1;
                    on_lvl = '0;
                    off_lvl = '0;
                    run_lvl = '0;
                end
                1:
                begin
                    k = '1;
                    on_lvl = '1;
                    off_lvl = '1;
                    run_lvl = '1;
                end
                2:
                begin
                    k = tpr_pkg::KReset;
                    on_lvl = tpr_pkg::CutOnReset;
                    off_lvl = tpr_pkg::CutOffReset;
                    run_lvl = tpr_pkg::RunReset;
                end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: k = 24'($urandom_range(1, 65535));
                        1: k = 24'($urandom);
                        default: k = 24'($urandom_range(100000, 4000000));
                    endcase
                    if ($urandom_range(0, 3) == 0)
                    begin
                        on_lvl = 16'($urandom);
                        off_lvl = 16'($urandom);
                    end
                    else
                    begin
                        on_lvl = 16'($urandom_range(40, 600));
                        off_lvl = on_lvl - 16'($urandom_range(0, 40));
                    end
                    run_lvl = 8'($urandom_range(0, 255));
                end
            endcase
            write_register(tpr_pkg::CfgSpeedConst, k);
            write_register(tpr_pkg::CfgCutOn, {8'd0, on_lvl});
            write_register(tpr_pkg::CfgCutOff, {8'd0, off_lvl});
            write_register(tpr_pkg::CfgRunLevel, {16'd0, run_lvl});
            no_idle = (phase == 3);
            if (phase == 5)
            begin
                hold_req = 1'b1;
            end
            repeat (PeriodsPerSet) send_period(pick_period(), 1'b0, NoResult);
        end

        wait_drained();
        repeat (30) @(negedge clk);
        if (pending_speeds.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_speeds.size());
            errors++;
        end
        $display("Sent %0d periods under %0d register writes, stalls and cutoff edges included.",
                 periods_sent, reg_writes);
        $display("Compared %0d speed results, %0d mismatches.", results_checked, errors);
        if (errors == 0)
        begin
            $display("tach_period_to_rpm_with_cutoff_tb: done, clean");
        end
        else
        begin
            $display("tach_period_to_rpm_with_cutoff_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: tach_period_to_rpm_with_cutoff.f
rtl/tpr_pkg.sv
rtl/tach_period_to_rpm_with_cutoff.sv
test/tach_period_to_rpm_with_cutoff_tb.sv
